### rtl/websocket_short_text_deframer_assert.svh
// Assertion macros used by the deframer top module.
`ifndef WEBSOCKET_SHORT_TEXT_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_SHORT_TEXT_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wsd_pkg.sv
// Package with codes, limits and the result type of the deframer.
package wsd_pkg;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    localparam logic [3:0] OPCODE_TEXT = 4'h1;
    localparam logic [6:0] LEN_MAX     = 7'd125;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       payload_last;
        logic [1:0] frame_status;
    } t_result;

endpackage

### rtl/wsd_core.sv
// Frame parser state and unmasking logic, one byte per step.
module wsd_core
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_rx_byte,
    input  logic       i_buffer_end,
    output t_result    o_result
);

    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_MASK = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_DROP = 3'd4;

    logic [2:0] r_phase, n_phase;
    logic [6:0] r_len, n_len;
    logic [6:0] r_idx, n_idx;
    logic [7:0] r_key [4];
    logic [7:0] n_key [4];
    t_result    res;
    logic       bad_hdr;
    logic       bad_len;
    logic       data_last;
    logic [7:0] unmasked;

    assign bad_hdr   = !i_rx_byte[7] || (i_rx_byte[3:0] != OPCODE_TEXT);
    assign bad_len   = i_rx_byte[6:0] > LEN_MAX;
    assign data_last = ({1'b0, r_idx} + 8'd1) >= {1'b0, r_len};
    assign unmasked  = i_rx_byte ^ r_key[r_idx[1:0]];

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_idx   = r_idx;
        n_key   = r_key;
        res     = '0;
        unique case (r_phase)
            PH_HDR: begin
                if (bad_hdr) begin
                    res.valid        = 1'b1;
                    res.frame_status = ST_BAD;
                    n_phase          = i_buffer_end ? PH_HDR : PH_DROP;
                    n_idx            = '0;
                end else if (i_buffer_end) begin
                    res.valid        = 1'b1;
                    res.frame_status = ST_TRUNC;
                    n_idx            = '0;
                end else begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_len = i_rx_byte[6:0];
                if (bad_len) begin
                    res.valid        = 1'b1;
                    res.frame_status = ST_BAD;
                    n_phase          = i_buffer_end ? PH_HDR : PH_DROP;
                    n_idx            = '0;
                end else if (i_buffer_end) begin
                    res.valid        = 1'b1;
                    res.frame_status = ST_TRUNC;
                    n_phase          = PH_HDR;
                    n_idx            = '0;
                end else begin
                    n_phase = PH_MASK;
                    n_idx   = '0;
                end
            end
            PH_MASK: begin
                n_key[r_idx[1:0]] = i_rx_byte;
                if (r_idx[1:0] == 2'd3) begin
                    n_idx = '0;
                    if (r_len == '0) begin
                        // Empty frame: the last key byte completes it.
                        res.valid        = 1'b1;
                        res.payload_last = 1'b1;
                        res.frame_status = ST_EMPTY;
                        n_phase          = i_buffer_end ? PH_HDR : PH_DROP;
                    end else if (i_buffer_end) begin
                        res.valid        = 1'b1;
                        res.frame_status = ST_TRUNC;
                        n_phase          = PH_HDR;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else if (i_buffer_end) begin
                    res.valid        = 1'b1;
                    res.frame_status = ST_TRUNC;
                    n_phase          = PH_HDR;
                    n_idx            = '0;
                end else begin
                    n_idx = r_idx + 7'd1;
                end
            end
            PH_DATA: begin
                if (data_last) begin
                    res.valid        = 1'b1;
                    res.payload_byte = unmasked;
                    res.payload_last = 1'b1;
                    res.frame_status = ST_DATA;
                    n_phase          = i_buffer_end ? PH_HDR : PH_DROP;
                    n_idx            = '0;
                end else if (i_buffer_end) begin
                    res.valid        = 1'b1;
                    res.frame_status = ST_TRUNC;
                    n_phase          = PH_HDR;
                    n_idx            = '0;
                end else begin
                    res.valid        = 1'b1;
                    res.payload_byte = unmasked;
                    res.frame_status = ST_DATA;
                    n_idx            = r_idx + 7'd1;
                end
            end
            default: begin
                // Dropping the tail of the buffer; unused codes behave the same.
                if (i_buffer_end) begin
                    n_phase = PH_HDR;
                    n_idx   = '0;
                end
            end
        endcase
        res.valid = res.valid && i_step;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_len   <= '0;
            r_idx   <= '0;
            r_key   <= '{default: '0};
        end else if (i_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_key   <= n_key;
        end
    end

endmodule

### rtl/websocket_short_text_deframer.sv
// A byte accepted into the input register passes the parse step into the result register
// once that register is free or being emptied; one byte per cycle while the result
// register is not held by a low i_out_ready.
// Reset: synchronous active-low i_rst_n empties both registers and returns the
// parser to the first header byte with length, index and mask key cleared.
module websocket_short_text_deframer
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_buffer_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_payload_last,
    output logic [1:0] o_frame_status
);

    `include "websocket_short_text_deframer_assert.svh"

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic [1:0] r_out_status;
    logic       advance;
    t_result    result;

    // The held byte moves on whenever the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    wsd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_rx_byte    (r_in_byte),
        .i_buffer_end (r_in_end),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
            r_in_end  <= i_buffer_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out_byte   <= result.payload_byte;
            r_out_last   <= result.payload_last;
            r_out_status <= result.frame_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_payload_last = r_out_last;
    assign o_frame_status = r_out_status;

    `WSD_ASSERT_NOW(a_nondata_zero, i_clk, i_rst_n,
        o_out_valid && (o_frame_status != ST_DATA),
        o_payload_byte == 8'd0, "non-data result carries a payload byte")
    `WSD_ASSERT_NOW(a_error_not_last, i_clk, i_rst_n,
        o_out_valid && ((o_frame_status == ST_BAD) || (o_frame_status == ST_TRUNC)),
        !o_payload_last, "error result marked last")
    `WSD_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n,
        !o_in_ready, r_in_valid && r_out_valid && !i_out_ready,
        "input stalled without a blocked result")
    `WSD_ASSERT_NEXT(a_held_byte_kept, i_clk, i_rst_n,
        r_in_valid && !advance,
        r_in_valid && $stable(r_in_byte) && $stable(r_in_end),
        "held byte lost while stalled")

endmodule
